/* rtl/point_cloud_corridor_clipper_assert.svh */
// Assertion macros used by the clipper top module.
`ifndef POINT_CLOUD_CORRIDOR_CLIPPER_ASSERT_SVH
`define POINT_CLOUD_CORRIDOR_CLIPPER_ASSERT_SVH

// Condition on one edge implies a consequent sequence starting on the same edge
`define PCCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pccc assertion failed");

// Condition on one edge implies a consequent sequence starting on the next edge
`define PCCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pccc assertion failed");

`endif

/* rtl/pccc_pkg.sv */
`default_nettype none

package pccc_pkg;

    // Polynomial order of the borders (1 or 2)
    localparam int POLY_ORDER = 2;

    // Register index width and codes
    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_LEFT_C0      = 4'd0;
    localparam cfg_idx_t REG_LEFT_C1      = 4'd1;
    localparam cfg_idx_t REG_LEFT_C2      = 4'd2;
    localparam cfg_idx_t REG_RIGHT_C0     = 4'd3;
    localparam cfg_idx_t REG_RIGHT_C1     = 4'd4;
    localparam cfg_idx_t REG_RIGHT_C2     = 4'd5;
    localparam cfg_idx_t REG_HEIGHT_LIMIT = 4'd6;
    localparam cfg_idx_t REG_FAR_LIMIT_SQ = 4'd7;

    // Reset values
    localparam logic [31:0] LEFT_C0_RST      = 32'hFFFD_0000;  // -3.0 m
    localparam logic [31:0] RIGHT_C0_RST     = 32'h0003_0000;  // +3.0 m
    localparam logic [31:0] FAR_LIMIT_SQ_RST = 32'hFFFF_FFFF;

    // Border coefficients, Q16.16
    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
    } border_coef_t;

    // Full configuration
    typedef struct packed {
        border_coef_t       left;
        border_coef_t       right;
        logic signed [15:0] height_limit;
        logic        [31:0] far_limit_sq;
    } cfg_t;

    // Load enables for the two border stages
    typedef struct packed {
        logic acc_en;
        logic poly_en;
    } stage_en_t;

endpackage

`default_nettype wire

/* rtl/point_cloud_corridor_clipper.sv */
// Point-cloud corridor clipper.
// Input: one point (point_x, point_y, point_z, signed Q8.8) is taken at a
// rising edge with start high and busy low. busy stays low: the pipeline
// takes a new point every cycle.
// Output: each point gives one result on out_x/out_y/out_z/clipped, shown
// for exactly one cycle with done high. A clipped point reads as zeros.
// Throughput: one point per cycle, set by the four-stage pipeline: input
// register, first Horner multiply and squares, second Horner multiply and
// distance test, border compare and output register.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register, cfg_data carries the value; cfg_ready is always high. Write only
// while no point is in flight; unknown indexes are ignored.
// Reset: rst_n clears the pipeline valid bits and loads register defaults
// (borders at -3 m and +3 m, height limit 0, far limit at its maximum).
// The receiver cannot stall; results are never held.
`default_nettype none
`include "point_cloud_corridor_clipper_assert.svh"

module point_cloud_corridor_clipper (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [15:0]       point_x,
    input  wire logic signed [15:0]       point_y,
    input  wire logic signed [15:0]       point_z,
    output logic                          done,
    output logic signed [15:0]            out_x,
    output logic signed [15:0]            out_y,
    output logic signed [15:0]            out_z,
    output logic                          clipped,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire pccc_pkg::cfg_idx_t       cfg_index,
    input  wire logic [31:0]              cfg_data
);
    import pccc_pkg::*;

    cfg_t               cfg;
    logic               accept;

    // Stage valid bits
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               s3_valid_reg;
    logic               done_reg;

    // Stage 1: captured point
    logic signed [15:0] s1_x_reg;
    logic signed [15:0] s1_y_reg;
    logic signed [15:0] s1_z_reg;

    // Stage 2: squares and height test
    logic signed [31:0] x_sq_prod;
    logic signed [31:0] z_sq_prod;
    logic        [30:0] s2_x_sq_reg;
    logic        [30:0] s2_z_sq_reg;
    logic               s2_low_reg;
    logic signed [15:0] s2_x_reg;
    logic signed [15:0] s2_y_reg;
    logic signed [15:0] s2_z_reg;

    // Stage 3: distance test
    logic        [31:0] dist_sq;
    logic               s3_clip_reg;
    logic signed [15:0] s3_x_reg;
    logic signed [15:0] s3_y_reg;
    logic signed [15:0] s3_z_reg;

    // Borders from the Horner units, aligned with stage 3
    stage_en_t          border_en;
    logic signed [63:0] left_border;
    logic signed [63:0] right_border;

    // Stage 4: border compare and result
    logic signed [63:0] x_scaled;
    logic               clip_next;
    logic signed [15:0] out_x_reg;
    logic signed [15:0] out_y_reg;
    logic signed [15:0] out_z_reg;
    logic               clipped_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers
    pccc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    // Stage 1: input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg <= point_x;
            s1_y_reg <= point_y;
            s1_z_reg <= point_z;
        end
    end

    // Stage 2: squares, height compare
    always_comb
    begin
        x_sq_prod = s1_x_reg * s1_x_reg;
        z_sq_prod = s1_z_reg * s1_z_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_x_sq_reg <= x_sq_prod[30:0];
            s2_z_sq_reg <= z_sq_prod[30:0];
            s2_low_reg  <= (s1_y_reg <= cfg.height_limit);
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_z_reg    <= s1_z_reg;
        end
    end

    // Stage 3: distance compare on squares
    assign dist_sq = {1'b0, s2_x_sq_reg} + {1'b0, s2_z_sq_reg};

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_clip_reg <= s2_low_reg || (dist_sq > cfg.far_limit_sq);
            s3_x_reg    <= s2_x_reg;
            s3_y_reg    <= s2_y_reg;
            s3_z_reg    <= s2_z_reg;
        end
    end

    // Border evaluation runs alongside stages 2 and 3
    assign border_en.acc_en  = s1_valid_reg;
    assign border_en.poly_en = s2_valid_reg;

    pccc_border u_left (
        .clk    (clk),
        .en     (border_en),
        .z      (s1_z_reg),
        .coef   (cfg.left),
        .border (left_border)
    );

    pccc_border u_right (
        .clk    (clk),
        .en     (border_en),
        .z      (s1_z_reg),
        .coef   (cfg.right),
        .border (right_border)
    );

    // Stage 4: x must lie strictly between the borders
    always_comb
    begin
        x_scaled  = {{24{s3_x_reg[15]}}, s3_x_reg, 24'b0};
        clip_next = s3_clip_reg
                 || !(x_scaled > left_border)
                 || !(x_scaled < right_border);
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            clipped_reg <= clip_next;
            out_x_reg   <= clip_next ? 16'sd0 : s3_x_reg;
            out_y_reg   <= clip_next ? 16'sd0 : s3_y_reg;
            out_z_reg   <= clip_next ? 16'sd0 : s3_z_reg;
        end
    end

    assign done    = done_reg;
    assign out_x   = out_x_reg;
    assign out_y   = out_y_reg;
    assign out_z   = out_z_reg;
    assign clipped = clipped_reg;

    // Every accepted point yields a result with done high
    `PCCC_ASSERT_NOW(a_result_latency, clk, rst_n, accept, ##4 done)
    // A clipped result is an all-zero point
    `PCCC_ASSERT_NOW(a_clip_zero, clk, rst_n, done && clipped,
        (out_x == 16'sd0) && (out_y == 16'sd0) && (out_z == 16'sd0))
    // A kept point is above the height limit
    `PCCC_ASSERT_NOW(a_kept_above, clk, rst_n, done && !clipped,
        out_y > cfg.height_limit)

endmodule

`default_nettype wire

/* rtl/pccc_regs.sv */
`default_nettype none

module pccc_regs (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire pccc_pkg::cfg_idx_t       cfg_index,
    input  wire logic [31:0]              cfg_data,
    output pccc_pkg::cfg_t                cfg
);
    import pccc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register file never pushes back
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEFT_C0:      cfg_next.left.c0      = cfg_data;
                REG_LEFT_C1:      cfg_next.left.c1      = cfg_data;
                REG_LEFT_C2:      cfg_next.left.c2      = cfg_data;
                REG_RIGHT_C0:     cfg_next.right.c0     = cfg_data;
                REG_RIGHT_C1:     cfg_next.right.c1     = cfg_data;
                REG_RIGHT_C2:     cfg_next.right.c2     = cfg_data;
                REG_HEIGHT_LIMIT: cfg_next.height_limit = cfg_data[15:0];
                REG_FAR_LIMIT_SQ: cfg_next.far_limit_sq = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left.c0      <= LEFT_C0_RST;
            cfg_reg.left.c1      <= '0;
            cfg_reg.left.c2      <= '0;
            cfg_reg.right.c0     <= RIGHT_C0_RST;
            cfg_reg.right.c1     <= '0;
            cfg_reg.right.c2     <= '0;
            cfg_reg.height_limit <= '0;
            cfg_reg.far_limit_sq <= FAR_LIMIT_SQ_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pccc_border.sv */
`default_nettype none

// Two-stage Horner evaluation of one border, scaled by 2^32:
//   acc = C2*Z + C1*256      (stage A)
//   F   = acc*Z + C0*65536   (stage B)
module pccc_border (
    input  wire logic                     clk,
    input  wire pccc_pkg::stage_en_t      en,
    input  wire logic signed [15:0]       z,
    input  wire pccc_pkg::border_coef_t   coef,
    output logic signed [63:0]            border
);
    import pccc_pkg::*;

    logic signed [31:0] c2_eff;
    logic signed [47:0] quad_prod;
    logic signed [48:0] acc_next;
    logic signed [48:0] acc_reg;
    logic signed [15:0] z_reg;
    logic signed [63:0] border_next;
    logic signed [63:0] border_reg;

    // First order drops the quadratic term
    assign c2_eff = (POLY_ORDER >= 2) ? coef.c2 : 32'sd0;

    // Stage A: quadratic term plus linear coefficient
    always_comb
    begin
        quad_prod = c2_eff * z;
        acc_next  = {quad_prod[47], quad_prod}
                  + {{9{coef.c1[31]}}, coef.c1, 8'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en.acc_en)
        begin
            acc_reg <= acc_next;
            z_reg   <= z;
        end
    end

    // Stage B: second multiply plus constant term, exact in 64 bits
    always_comb
    begin
        border_next = acc_reg * z_reg + $signed({{16{coef.c0[31]}}, coef.c0, 16'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en.poly_en)
        begin
            border_reg <= border_next;
        end
    end

    assign border = border_reg;

endmodule

`default_nettype wire
